>>> rtl/mcr_pkg.sv
package mcr_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int RADIUS_BITS = 15;
  localparam int STEP_BITS = 16;
  localparam int DEC_BITS = 20;
  localparam int COLOR_BITS = 32;
  localparam int OP_BITS = 2;
  localparam int REG_INDEX_BITS = 1;
  localparam int IDX_BITS = 3;

  localparam logic [OP_BITS-1:0] OP_OUTLINE = 2'd0;
  localparam logic [OP_BITS-1:0] OP_FILLED = 2'd1;
  localparam logic [OP_BITS-1:0] OP_STEP = 2'd2;

  localparam logic [REG_INDEX_BITS-1:0] REG_CAMERA_X = 1'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_CAMERA_Y = 1'd1;

  localparam logic [DEC_BITS-1:0] DEC_INIT = 20'd3;
  localparam logic [DEC_BITS-1:0] DEC_INC_HOLD = 20'd6;
  localparam logic [DEC_BITS-1:0] DEC_INC_DIAG = 20'd10;

  localparam logic [IDX_BITS-1:0] SPAN_LAST = 3'd3;
  localparam logic [IDX_BITS-1:0] POINT_LAST = 3'd7;

  typedef struct packed {
    logic filled;
    logic done;
  } iter_ctl_t;

endpackage

>>> rtl/mcr_queue.sv
module mcr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full = (count == CNT_BITS'(DEPTH));
  assign empty = (count == '0);
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

>>> rtl/mcr_front.sv
module mcr_front #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  write_enable,
  input  logic [mcr_pkg::REG_INDEX_BITS-1:0]    register_index,
  input  logic [COORD_BITS-1:0]                 write_data,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [mcr_pkg::OP_BITS-1:0]           operation,
  input  logic signed [COORD_BITS-1:0]          center_x,
  input  logic signed [COORD_BITS-1:0]          center_y,
  input  logic [mcr_pkg::RADIUS_BITS-1:0]       radius,
  input  logic [mcr_pkg::COLOR_BITS-1:0]        color,
  input  logic                                  queue_full,
  output logic                                  rec_push,
  output logic [COORD_BITS:0]                   rec_cx,
  output logic [COORD_BITS:0]                   rec_cy,
  output logic [mcr_pkg::STEP_BITS-1:0]         rec_a,
  output logic [mcr_pkg::STEP_BITS-1:0]         rec_b,
  output logic [mcr_pkg::COLOR_BITS-1:0]        rec_color,
  output mcr_pkg::iter_ctl_t                    rec_ctl
);

  localparam int SB = mcr_pkg::STEP_BITS;
  localparam int DB = mcr_pkg::DEC_BITS;

  logic [COORD_BITS-1:0] camera_x;
  logic [COORD_BITS-1:0] camera_y;
  logic active;
  logic filled_mode;
  logic [COORD_BITS:0] screen_cx;
  logic [COORD_BITS:0] screen_cy;
  logic [SB-1:0] step_x;
  logic [SB-1:0] step_y;
  logic [DB-1:0] decision;
  logic [mcr_pkg::COLOR_BITS-1:0] held_color;

  logic accept;
  logic is_start;
  logic is_step;
  logic fire;
  logic rec_filled;
  logic [SB-1:0] a0;
  logic [SB-1:0] b0;
  logic [DB-1:0] d0;
  logic [SB-1:0] step_x_next;
  logic [SB-1:0] step_y_next;
  logic [DB-1:0] decision_next;
  logic done_next;

  assign item_stall = queue_full;
  assign accept = item_valid && !item_stall;
  assign is_start = (operation == mcr_pkg::OP_OUTLINE) || (operation == mcr_pkg::OP_FILLED);
  assign is_step = (operation == mcr_pkg::OP_STEP);
  assign fire = accept && ((is_start && (radius != '0)) || (is_step && active));

  always_comb begin
    if (is_start) begin
      a0 = '0;
      b0 = SB'(radius);
      d0 = mcr_pkg::DEC_INIT - (DB'(radius) << 1);
      rec_cx = {center_x[COORD_BITS-1], center_x} - {camera_x[COORD_BITS-1], camera_x};
      rec_cy = {center_y[COORD_BITS-1], center_y} - {camera_y[COORD_BITS-1], camera_y};
      rec_color = color;
      rec_filled = (operation == mcr_pkg::OP_FILLED);
    end else begin
      a0 = step_x;
      b0 = step_y;
      d0 = decision;
      rec_cx = screen_cx;
      rec_cy = screen_cy;
      rec_color = held_color;
      rec_filled = filled_mode;
    end
  end

  always_comb begin
    step_x_next = a0 + SB'(1);
    if (d0[DB-1]) begin
      decision_next = d0 + (DB'(a0) << 2) + mcr_pkg::DEC_INC_HOLD;
      step_y_next = b0;
    end else begin
      decision_next = d0 + ((DB'(a0) - DB'(b0)) << 2) + mcr_pkg::DEC_INC_DIAG;
      step_y_next = b0 - SB'(1);
    end
    done_next = (step_y_next < step_x_next);
  end

  assign rec_push = fire;
  assign rec_a = a0;
  assign rec_b = b0;
  assign rec_ctl = '{filled: rec_filled, done: done_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
    end else if (write_enable) begin
      unique case (register_index)
        mcr_pkg::REG_CAMERA_X: camera_x <= write_data;
        mcr_pkg::REG_CAMERA_Y: camera_y <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (fire) begin
      active <= !done_next;
    end else if (accept && is_start) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x <= '0;
      step_y <= '0;
      decision <= '0;
      screen_cx <= '0;
      screen_cy <= '0;
      held_color <= '0;
      filled_mode <= 1'b0;
    end else if (fire) begin
      step_x <= step_x_next;
      step_y <= step_y_next;
      decision <= decision_next;
      screen_cx <= rec_cx;
      screen_cy <= rec_cy;
      held_color <= rec_color;
      filled_mode <= rec_filled;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idles: assert property (@(posedge clk) disable iff (rst)
      rec_push && rec_ctl.done |=> !active)
    else $error("circle still active after its final iteration");
`endif

endmodule

>>> rtl/mcr_back.sv
module mcr_back #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  queue_empty,
  output logic                                  queue_pop,
  input  logic [COORD_BITS:0]                   rec_cx,
  input  logic [COORD_BITS:0]                   rec_cy,
  input  logic [mcr_pkg::STEP_BITS-1:0]         rec_a,
  input  logic [mcr_pkg::STEP_BITS-1:0]         rec_b,
  input  logic [mcr_pkg::COLOR_BITS-1:0]        rec_color,
  input  mcr_pkg::iter_ctl_t                    rec_ctl,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [COORD_BITS:0]            x_begin,
  output logic signed [COORD_BITS:0]            y_begin,
  output logic signed [COORD_BITS:0]            x_finish,
  output logic signed [COORD_BITS:0]            y_finish,
  output logic [mcr_pkg::COLOR_BITS-1:0]        pixel_color,
  output logic                                  is_span,
  output logic                                  last_of_iteration,
  output logic                                  circle_done
);

  localparam int OB = COORD_BITS + 1;

  logic cur_valid;
  logic [OB-1:0] cur_cx;
  logic [OB-1:0] cur_cy;
  logic [mcr_pkg::STEP_BITS-1:0] cur_a;
  logic [mcr_pkg::STEP_BITS-1:0] cur_b;
  logic [mcr_pkg::COLOR_BITS-1:0] cur_color;
  mcr_pkg::iter_ctl_t cur_ctl;
  logic [mcr_pkg::IDX_BITS-1:0] idx;

  logic adv;
  logic at_last;
  logic load;
  logic [OB-1:0] a_o;
  logic [OB-1:0] b_o;
  logic [OB-1:0] cx_pa, cx_ma, cx_pb, cx_mb;
  logic [OB-1:0] cy_pa, cy_ma, cy_pb, cy_mb;
  logic [OB-1:0] xb_n, yb_n, xf_n, yf_n;

  assign at_last = (idx == (cur_ctl.filled ? mcr_pkg::SPAN_LAST : mcr_pkg::POINT_LAST));
  assign adv = cur_valid && (!result_valid || !result_stall);
  assign load = !queue_empty && (!cur_valid || (adv && at_last));
  assign queue_pop = load;

  assign a_o = OB'(cur_a);
  assign b_o = OB'(cur_b);
  assign cx_pa = cur_cx + a_o;
  assign cx_ma = cur_cx - a_o;
  assign cx_pb = cur_cx + b_o;
  assign cx_mb = cur_cx - b_o;
  assign cy_pa = cur_cy + a_o;
  assign cy_ma = cur_cy - a_o;
  assign cy_pb = cur_cy + b_o;
  assign cy_mb = cur_cy - b_o;

  always_comb begin
    xb_n = cx_ma;
    xf_n = cx_pa;
    yb_n = cy_mb;
    if (cur_ctl.filled) begin
      case (idx)
        3'd0: begin xb_n = cx_ma; xf_n = cx_pa; yb_n = cy_mb; end
        3'd1: begin xb_n = cx_mb; xf_n = cx_pb; yb_n = cy_ma; end
        3'd2: begin xb_n = cx_ma; xf_n = cx_pa; yb_n = cy_pb; end
        3'd3: begin xb_n = cx_mb; xf_n = cx_pb; yb_n = cy_pa; end
        default: ;
      endcase
    end else begin
      case (idx)
        3'd0: begin xb_n = cx_pa; yb_n = cy_mb; end
        3'd1: begin xb_n = cx_pb; yb_n = cy_ma; end
        3'd2: begin xb_n = cx_pb; yb_n = cy_pa; end
        3'd3: begin xb_n = cx_pa; yb_n = cy_pb; end
        3'd4: begin xb_n = cx_ma; yb_n = cy_pb; end
        3'd5: begin xb_n = cx_mb; yb_n = cy_pa; end
        3'd6: begin xb_n = cx_mb; yb_n = cy_ma; end
        default: begin xb_n = cx_ma; yb_n = cy_mb; end
      endcase
      xf_n = xb_n;
    end
    yf_n = yb_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
        idx <= '0;
      end else if (adv) begin
        if (at_last) begin
          cur_valid <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
      if (adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_cx <= rec_cx;
      cur_cy <= rec_cy;
      cur_a <= rec_a;
      cur_b <= rec_b;
      cur_color <= rec_color;
      cur_ctl <= rec_ctl;
    end
    if (adv) begin
      x_begin <= xb_n;
      y_begin <= yb_n;
      x_finish <= xf_n;
      y_finish <= yf_n;
      pixel_color <= cur_color;
      is_span <= cur_ctl.filled;
      last_of_iteration <= at_last;
      circle_done <= at_last && cur_ctl.done;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
      result_valid && circle_done |-> last_of_iteration)
    else $error("circle completion flagged before the end of an iteration");
  a_point_shape: assert property (@(posedge clk) disable iff (rst)
      result_valid && !is_span |-> (x_begin == x_finish) && (y_begin == y_finish))
    else $error("point result with differing end coordinates");
  a_span_flat: assert property (@(posedge clk) disable iff (rst)
      result_valid && is_span |-> (y_begin == y_finish))
    else $error("span result is not horizontal");
`endif

endmodule

>>> rtl/midpoint_circle_rasterizer_core.sv
// The first result of a transaction is written into the queue, loaded into the sequencer's
// current-record register and then registered onto the result port. A filled iteration gives
// four results and an outline iteration eight, one result per cycle while result_stall is low.
// A four-entry queue between the iteration update and the result sequencer sets how far
// the input side may run ahead. Reset is synchronous and clears the camera registers,
// the circle state and all valid flags; the block accepts transactions right after reset.
module midpoint_circle_rasterizer_core #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = mcr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  write_enable,
  input  logic [mcr_pkg::REG_INDEX_BITS-1:0]    register_index,
  input  logic [COORD_BITS-1:0]                 write_data,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [mcr_pkg::OP_BITS-1:0]           operation,
  input  logic signed [COORD_BITS-1:0]          center_x,
  input  logic signed [COORD_BITS-1:0]          center_y,
  input  logic [mcr_pkg::RADIUS_BITS-1:0]       radius,
  input  logic [mcr_pkg::COLOR_BITS-1:0]        color,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [COORD_BITS:0]            x_begin,
  output logic signed [COORD_BITS:0]            y_begin,
  output logic signed [COORD_BITS:0]            x_finish,
  output logic signed [COORD_BITS:0]            y_finish,
  output logic [mcr_pkg::COLOR_BITS-1:0]        pixel_color,
  output logic                                  is_span,
  output logic                                  last_of_iteration,
  output logic                                  circle_done
);

  localparam int OB = COORD_BITS + 1;
  localparam int REC_BITS = 2 * OB + 2 * mcr_pkg::STEP_BITS + mcr_pkg::COLOR_BITS
                            + $bits(mcr_pkg::iter_ctl_t);

  logic queue_full;
  logic queue_empty;
  logic queue_pop;
  logic rec_push;
  logic [OB-1:0] f_cx, f_cy, b_cx, b_cy;
  logic [mcr_pkg::STEP_BITS-1:0] f_a, f_b, b_a, b_b;
  logic [mcr_pkg::COLOR_BITS-1:0] f_color, b_color;
  mcr_pkg::iter_ctl_t f_ctl, b_ctl;
  logic [REC_BITS-1:0] q_din;
  logic [REC_BITS-1:0] q_dout;

  mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .register_index(register_index),
    .write_data(write_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .center_x(center_x),
    .center_y(center_y),
    .radius(radius),
    .color(color),
    .queue_full(queue_full),
    .rec_push(rec_push),
    .rec_cx(f_cx),
    .rec_cy(f_cy),
    .rec_a(f_a),
    .rec_b(f_b),
    .rec_color(f_color),
    .rec_ctl(f_ctl)
  );

  assign q_din = {f_cx, f_cy, f_a, f_b, f_color, f_ctl};
  assign {b_cx, b_cy, b_a, b_b, b_color, b_ctl} = q_dout;

  mcr_queue #(.WIDTH(REC_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(rec_push),
    .din(q_din),
    .full(queue_full),
    .pop(queue_pop),
    .dout(q_dout),
    .empty(queue_empty)
  );

  mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk(clk),
    .rst(rst),
    .queue_empty(queue_empty),
    .queue_pop(queue_pop),
    .rec_cx(b_cx),
    .rec_cy(b_cy),
    .rec_a(b_a),
    .rec_b(b_b),
    .rec_color(b_color),
    .rec_ctl(b_ctl),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .x_begin(x_begin),
    .y_begin(y_begin),
    .x_finish(x_finish),
    .y_finish(y_finish),
    .pixel_color(pixel_color),
    .is_span(is_span),
    .last_of_iteration(last_of_iteration),
    .circle_done(circle_done)
  );

endmodule
